FILE: hw/rtl/pdca_pkg.sv
// Shared types, constants and the CRC-8 byte step for the packet deframer.
package pdca_pkg;

	localparam int DATA_BYTES_DEF   = 16;
	localparam int RING_PACKETS_DEF = 8;
	localparam int QUEUE_DEPTH      = 4;
	localparam int CFG_INDEX_W      = 2;

	localparam logic [CFG_INDEX_W-1:0] CFG_IDX_POLY    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_IDX_INITIAL = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_IDX_ACK     = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_IDX_RETX    = 2'd3;

	localparam logic [7:0] POLY_RESET    = 8'd7;
	localparam logic [7:0] INITIAL_RESET = 8'd0;
	localparam logic [7:0] ACK_RESET     = 8'd21;
	localparam logic [7:0] RETX_RESET    = 8'd25;
	localparam logic [7:0] FILL_BYTE     = 8'hff;

	typedef struct packed {
		logic [7:0] crc_polynomial;
		logic [7:0] crc_initial;
		logic [7:0] ack_code;
		logic [7:0] retx_code;
	} cfg_t;

	typedef enum logic [1:0] {
		CMD_ACK,
		CMD_RETX,
		CMD_READ,
		CMD_EMPTY
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic      waiting;
		logic      overflow;
	} cmd_t;

	// One CRC-8 byte update, MSB first, top bit of the generator implicit.
	function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b,
			input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ((c << 1) ^ poly) : (c << 1);
		end
		return c;
	endfunction

endpackage

FILE: hw/rtl/pdca_ring.sv
// Packet ring storage: one write port, one registered read port.
module pdca_ring #(
	parameter int DEPTH  = 180,
	parameter int ADDR_W = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [7:0]        rdata
);

	logic [7:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/pdca_front.sv
// Front end: frames received bytes, checks the CRC and issues output commands.
module pdca_front #(
	parameter int DATA_BYTES   = pdca_pkg::DATA_BYTES_DEF,
	parameter int RING_PACKETS = pdca_pkg::RING_PACKETS_DEF,
	localparam int PKT_LEN = DATA_BYTES + 2,
	localparam int SLOTS   = RING_PACKETS + 2,
	localparam int IDX_W   = $clog2(PKT_LEN),
	localparam int SLOT_W  = $clog2(SLOTS),
	localparam int ADDR_W  = $clog2(SLOTS * PKT_LEN)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pdca_pkg::cfg_t      cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_op,
	input  logic [7:0]          in_byte,
	output logic                push,
	output pdca_pkg::cmd_t      push_cmd,
	output logic [SLOT_W-1:0]   push_slot,
	input  logic                q_full,
	input  logic                read_done,
	output logic                we,
	output logic [ADDR_W-1:0]   waddr,
	output logic [7:0]          wdata
);

	localparam int CNT_W  = $clog2(RING_PACKETS + 1);
	localparam int IF_W   = $clog2(pdca_pkg::QUEUE_DEPTH + 2);
	localparam int HELD_W = $clog2(SLOTS + pdca_pkg::QUEUE_DEPTH + 2);
	localparam logic [ADDR_W-1:0] PKT_LEN_A = ADDR_W'(PKT_LEN);

	typedef enum logic [1:0] {
		PH_LENGTH,
		PH_DATA,
		PH_CRC
	} phase_t;

	phase_t              phase_q;
	logic [IDX_W-1:0]    idx_q;
	logic [7:0]          crc_q;
	logic                len_one_q;
	logic [7:0]          first_q;
	logic                rest_ff_q;
	logic [CNT_W-1:0]    stored_q;
	logic [IF_W-1:0]     inflight_q;
	logic [SLOT_W-1:0]   wp_q;
	logic [SLOT_W-1:0]   rp_q;
	logic                ovf_q;

	logic                accept;
	logic                rx;
	logic                rd;
	logic [HELD_W-1:0]   held;
	logic                in_length;
	logic [IDX_W-1:0]    wr_idx;
	logic [7:0]          crc_next;
	logic                crc_bad;
	logic                is_retx;
	logic                is_ack;
	logic                ring_full;
	logic                at_crc;
	logic                commit;
	logic                drop_full;
	logic                pop_slot;

	// A slot is held while it stores a packet or while the back end still reads it;
	// the slot under construction is the next free one.
	assign held      = HELD_W'(stored_q) + HELD_W'(inflight_q);
	assign in_ready  = !q_full && (held < HELD_W'(SLOTS));
	assign accept    = in_valid && in_ready;
	assign rx        = accept && !in_op;
	assign rd        = accept && in_op;

	assign in_length = (phase_q != PH_DATA) && (phase_q != PH_CRC);
	assign at_crc    = rx && (phase_q == PH_CRC);
	assign wr_idx    = in_length ? '0 : idx_q;
	assign crc_next  = pdca_pkg::crc_step(in_length ? cfg.crc_initial : crc_q, in_byte,
			cfg.crc_polynomial);

	assign crc_bad   = in_byte != crc_q;
	assign is_retx   = len_one_q && (first_q == cfg.retx_code) && rest_ff_q;
	assign is_ack    = len_one_q && (first_q == cfg.ack_code) && rest_ff_q;
	assign ring_full = stored_q >= CNT_W'(RING_PACKETS);
	assign commit    = at_crc && !crc_bad && !is_retx && !is_ack && !ring_full;
	assign drop_full = at_crc && !crc_bad && !is_retx && !is_ack && ring_full;
	assign pop_slot  = rd && (stored_q != '0);

	assign we    = rx;
	assign waddr = ADDR_W'(wp_q) * PKT_LEN_A + ADDR_W'(wr_idx);
	assign wdata = in_byte;

	always_comb begin
		push      = 1'b0;
		push_slot = rp_q;
		push_cmd  = '{kind: pdca_pkg::CMD_ACK, waiting: stored_q != '0, overflow: ovf_q};
		if (rd) begin
			push = 1'b1;
			if (stored_q == '0) begin
				push_cmd.kind    = pdca_pkg::CMD_EMPTY;
				push_cmd.waiting = 1'b0;
			end else begin
				push_cmd.kind    = pdca_pkg::CMD_READ;
				push_cmd.waiting = stored_q != CNT_W'(1);
			end
		end else if (at_crc) begin
			if (crc_bad || is_retx) begin
				push          = 1'b1;
				push_cmd.kind = pdca_pkg::CMD_RETX;
			end else if (!is_ack) begin
				push              = 1'b1;
				push_cmd.waiting  = 1'b1;
				push_cmd.overflow = ovf_q || ring_full;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_LENGTH;
			idx_q      <= '0;
			crc_q      <= pdca_pkg::INITIAL_RESET;
			stored_q   <= '0;
			inflight_q <= '0;
			wp_q       <= '0;
			rp_q       <= '0;
			ovf_q      <= 1'b0;
		end else begin
			if (rx) begin
				unique case (phase_q)
					PH_DATA: begin
						crc_q <= crc_next;
						idx_q <= idx_q + IDX_W'(1);
						if (idx_q == IDX_W'(DATA_BYTES)) begin
							phase_q <= PH_CRC;
						end
					end
					PH_CRC: begin
						phase_q <= PH_LENGTH;
					end
					default: begin
						crc_q   <= crc_next;
						idx_q   <= IDX_W'(1);
						phase_q <= PH_DATA;
					end
				endcase
			end
			if (commit) begin
				stored_q <= stored_q + CNT_W'(1);
				wp_q     <= (wp_q == SLOT_W'(SLOTS - 1)) ? '0 : wp_q + SLOT_W'(1);
			end else if (pop_slot) begin
				stored_q <= stored_q - CNT_W'(1);
				rp_q     <= (rp_q == SLOT_W'(SLOTS - 1)) ? '0 : rp_q + SLOT_W'(1);
			end
			if (pop_slot && !read_done) begin
				inflight_q <= inflight_q + IF_W'(1);
			end else if (!pop_slot && read_done) begin
				inflight_q <= inflight_q - IF_W'(1);
			end
			if (drop_full) begin
				ovf_q <= 1'b1;
			end
		end
	end

	// Control-packet match flags, built up byte by byte.
	always_ff @(posedge clk) begin
		if (rx) begin
			if (in_length) begin
				len_one_q <= in_byte == 8'd1;
				rest_ff_q <= 1'b1;
			end else if (phase_q == PH_DATA) begin
				if (idx_q == IDX_W'(1)) begin
					first_q <= in_byte;
				end else begin
					rest_ff_q <= rest_ff_q && (in_byte == pdca_pkg::FILL_BYTE);
				end
			end
		end
	end

endmodule

FILE: hw/rtl/pdca_cmdq.sv
// Small command queue between the front end and the back end.
module pdca_cmdq #(
	parameter int WIDTH = 8,
	parameter int DEPTH = pdca_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;

	assign full     = count_q == CNT_W'(DEPTH);
	assign valid    = count_q != '0;
	assign pop_data = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (!push && pop) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

FILE: hw/rtl/pdca_back.sv
// Back end: turns commands into output bytes through a fetch stage and an output register.
module pdca_back #(
	parameter int DATA_BYTES   = pdca_pkg::DATA_BYTES_DEF,
	parameter int RING_PACKETS = pdca_pkg::RING_PACKETS_DEF,
	localparam int PKT_LEN = DATA_BYTES + 2,
	localparam int SLOTS   = RING_PACKETS + 2,
	localparam int IDX_W   = $clog2(PKT_LEN),
	localparam int SLOT_W  = $clog2(SLOTS),
	localparam int ADDR_W  = $clog2(SLOTS * PKT_LEN)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pdca_pkg::cfg_t      cfg,
	input  logic                cmd_valid,
	input  pdca_pkg::cmd_t      cmd,
	input  logic [SLOT_W-1:0]   cmd_slot,
	output logic                pop,
	output logic                read_done,
	output logic                re,
	output logic [ADDR_W-1:0]   raddr,
	input  logic [7:0]          rdata,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                out_kind,
	output logic [7:0]          out_byte,
	output logic                out_last,
	output logic                out_waiting,
	output logic                out_overflow,
	output logic                out_empty
);

	localparam logic [ADDR_W-1:0] PKT_LEN_A = ADDR_W'(PKT_LEN);

	logic                busy_q;
	pdca_pkg::cmd_t      cmd_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [IDX_W-1:0]    idx_q;
	logic [7:0]          crc_q;

	logic                v_s1;
	logic [7:0]          byte_s1;
	logic                mem_s1;
	logic                kind_s1;
	logic                last_s1;
	logic                waiting_s1;
	logic                ovf_s1;
	logic                empty_s1;

	logic                move_s1;
	logic                s1_free;
	logic                issue;
	logic                is_last;
	logic [7:0]          byte_c;
	logic [7:0]          code_c;

	assign move_s1 = v_s1 && (!out_valid || out_ready);
	assign s1_free = !v_s1 || move_s1;
	assign issue   = busy_q && s1_free;
	assign pop     = !busy_q && cmd_valid;
	assign is_last = (cmd_q.kind == pdca_pkg::CMD_EMPTY) || (idx_q == IDX_W'(PKT_LEN - 1));
	assign code_c  = (cmd_q.kind == pdca_pkg::CMD_RETX) ? cfg.retx_code : cfg.ack_code;

	assign re        = issue && (cmd_q.kind == pdca_pkg::CMD_READ);
	assign raddr     = ADDR_W'(slot_q) * PKT_LEN_A + ADDR_W'(idx_q);
	assign read_done = re && is_last;

	always_comb begin
		byte_c = 8'd0;
		case (cmd_q.kind) inside
			pdca_pkg::CMD_ACK, pdca_pkg::CMD_RETX: begin
				if (idx_q == '0) begin
					byte_c = 8'd1;
				end else if (idx_q == IDX_W'(1)) begin
					byte_c = code_c;
				end else if (is_last) begin
					byte_c = crc_q;
				end else begin
					byte_c = pdca_pkg::FILL_BYTE;
				end
			end
			default: byte_c = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			v_s1      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (issue && is_last) begin
				busy_q <= 1'b0;
			end
			if (issue) begin
				v_s1 <= 1'b1;
			end else if (move_s1) begin
				v_s1 <= 1'b0;
			end
			if (move_s1) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q  <= cmd;
			slot_q <= cmd_slot;
			idx_q  <= '0;
			crc_q  <= cfg.crc_initial;
		end else if (issue) begin
			idx_q <= idx_q + IDX_W'(1);
			crc_q <= pdca_pkg::crc_step(crc_q, byte_c, cfg.crc_polynomial);
		end
		if (issue) begin
			byte_s1    <= byte_c;
			mem_s1     <= cmd_q.kind == pdca_pkg::CMD_READ;
			kind_s1    <= (cmd_q.kind == pdca_pkg::CMD_READ) ||
					(cmd_q.kind == pdca_pkg::CMD_EMPTY);
			last_s1    <= is_last;
			waiting_s1 <= cmd_q.waiting;
			ovf_s1     <= cmd_q.overflow;
			empty_s1   <= cmd_q.kind == pdca_pkg::CMD_EMPTY;
		end
		if (move_s1) begin
			out_byte     <= mem_s1 ? rdata : byte_s1;
			out_kind     <= kind_s1;
			out_last     <= last_s1;
			out_waiting  <= waiting_s1;
			out_overflow <= ovf_s1;
			out_empty    <= empty_s1;
		end
	end

endmodule

FILE: hw/rtl/packet_deframer_crc_ack.sv
// Top level of the fixed-length packet deframer with CRC-8 check and acknowledge.
//
//   Channel   Direction  Handshake                      Contents
//   s_axis    in         s_axis_tvalid / s_axis_tready   operation, received link byte
//   m_axis    out        m_axis_tvalid / m_axis_tready   one emitted byte with status
//   cfg       in         cfg_valid / cfg_ready           register index and write data
//
// The input side takes one byte per cycle while s_axis_tready is high, which drops only while
// the command queue is full or every ring slot is held; framing and the CRC update finish in
// that cycle. Each read and each packet but a good acknowledge makes a command; the back end
// emits the 18 bytes of a packet (DATA_BYTES + 2 in general), or one byte for an empty read,
// at one per cycle while m_axis_tready allows. Ring reads are registered, hidden by the fetch
// stage. Reset clears all control state at once; packet storage needs no clearing pass.
module packet_deframer_crc_ack #(
	parameter int DATA_BYTES   = pdca_pkg::DATA_BYTES_DEF,
	parameter int RING_PACKETS = pdca_pkg::RING_PACKETS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [7:0]                       s_axis_tdata,   // [7:0] rx_byte
	input  logic                             s_axis_tuser,   // [0] operation
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [7:0] out_byte, [8] packets_waiting, [9] overflow, [10] read_empty, [15:11] zero
	output logic [15:0]                      m_axis_tdata,
	output logic                             m_axis_tuser,   // [0] out_kind
	output logic                             m_axis_tlast,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pdca_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]                       cfg_data
);

	localparam int PKT_LEN = DATA_BYTES + 2;
	localparam int SLOTS   = RING_PACKETS + 2;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int ADDR_W  = $clog2(SLOTS * PKT_LEN);
	localparam int CMD_W   = $bits(pdca_pkg::cmd_t) + SLOT_W;

	pdca_pkg::cfg_t    cfg_q;

	logic              push;
	pdca_pkg::cmd_t    push_cmd;
	logic [SLOT_W-1:0] push_slot;
	logic              q_full;
	logic              q_valid;
	logic              q_pop;
	logic [CMD_W-1:0]  q_data;
	pdca_pkg::cmd_t    pop_cmd;
	logic [SLOT_W-1:0] pop_slot;
	logic              read_done;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [7:0]        wdata;
	logic              re;
	logic [ADDR_W-1:0] raddr;
	logic [7:0]        rdata;

	logic              out_waiting;
	logic              out_overflow;
	logic              out_empty;
	logic [7:0]        out_byte;

	// Configuration registers; a write is always taken in the cycle it is offered.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.crc_polynomial <= pdca_pkg::POLY_RESET;
			cfg_q.crc_initial    <= pdca_pkg::INITIAL_RESET;
			cfg_q.ack_code       <= pdca_pkg::ACK_RESET;
			cfg_q.retx_code      <= pdca_pkg::RETX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pdca_pkg::CFG_IDX_POLY:    cfg_q.crc_polynomial <= cfg_data;
				pdca_pkg::CFG_IDX_INITIAL: cfg_q.crc_initial    <= cfg_data;
				pdca_pkg::CFG_IDX_ACK:     cfg_q.ack_code       <= cfg_data;
				pdca_pkg::CFG_IDX_RETX:    cfg_q.retx_code      <= cfg_data;
				default: ;
			endcase
		end
	end

	// The front end frames bytes straight into the next free ring slot, so a good packet
	// is stored by moving the write slot on rather than by copying it.
	pdca_front #(
		.DATA_BYTES   (DATA_BYTES),
		.RING_PACKETS (RING_PACKETS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tuser),
		.in_byte   (s_axis_tdata),
		.push      (push),
		.push_cmd  (push_cmd),
		.push_slot (push_slot),
		.q_full    (q_full),
		.read_done (read_done),
		.we        (we),
		.waddr     (waddr),
		.wdata     (wdata)
	);

	// Each command carries the status flags as they stood right after its transaction.
	pdca_cmdq #(
		.WIDTH (CMD_W),
		.DEPTH (pdca_pkg::QUEUE_DEPTH)
	) u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_cmd, push_slot}),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (q_data)
	);

	assign pop_cmd  = pdca_pkg::cmd_t'(q_data[CMD_W-1:SLOT_W]);
	assign pop_slot = q_data[SLOT_W-1:0];

	pdca_ring #(
		.DEPTH  (SLOTS * PKT_LEN),
		.ADDR_W (ADDR_W)
	) u_ring (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	pdca_back #(
		.DATA_BYTES   (DATA_BYTES),
		.RING_PACKETS (RING_PACKETS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd_valid    (q_valid),
		.cmd          (pop_cmd),
		.cmd_slot     (pop_slot),
		.pop          (q_pop),
		.read_done    (read_done),
		.re           (re),
		.raddr        (raddr),
		.rdata        (rdata),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_kind     (m_axis_tuser),
		.out_byte     (out_byte),
		.out_last     (m_axis_tlast),
		.out_waiting  (out_waiting),
		.out_overflow (out_overflow),
		.out_empty    (out_empty)
	);

	assign m_axis_tdata = {5'd0, out_empty, out_overflow, out_waiting, out_byte};

endmodule

FILE: hw/rtl/pdca_checker.sv
// Port-level checks for the packet deframer, bound to its top level.
module pdca_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        m_axis_tuser,
	input logic        m_axis_tlast
);

	logic seen_ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_ovf_q <= 1'b0;
		end else if (m_axis_tvalid && m_axis_tready && m_axis_tdata[9]) begin
			seen_ovf_q <= 1'b1;
		end
	end

	// A stalled output transaction keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
			m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
			$stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("output changed while stalled");

	// An empty read is a lone read-out byte of zero that closes its packet.
	a_empty_form: assert property (@(posedge clk) disable iff (!arst_n)
			m_axis_tvalid && m_axis_tdata[10] |->
			m_axis_tuser && m_axis_tlast && (m_axis_tdata[7:0] == 8'd0))
		else $error("malformed empty-read byte");

	// An empty read never reports a waiting packet.
	a_empty_none: assert property (@(posedge clk) disable iff (!arst_n)
			m_axis_tvalid && m_axis_tdata[10] |-> !m_axis_tdata[8])
		else $error("empty read with packets waiting");

	// Once reported, the overflow flag stays set until reset.
	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
			m_axis_tvalid && seen_ovf_q |-> m_axis_tdata[9])
		else $error("overflow flag cleared");

endmodule

bind packet_deframer_crc_ack pdca_checker u_pdca_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

FILE: test/tb.sv
// Self-checking testbench for the packet deframer: framing, CRC, ack/retransmit and ring reads.
module tb;

	localparam int DB     = pdca_pkg::DATA_BYTES_DEF;
	localparam int PKT    = DB + 2;
	localparam int RING   = pdca_pkg::RING_PACKETS_DEF;
	// Cycles to let pass after the last expected byte before touching registers or ending.
	localparam int SETTLE = 40;

	typedef enum bit {
		OP_RX   = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		PH_LEN,
		PH_DATA,
		PH_CRC
	} frame_phase_t;

	localparam bit KIND_LINK    = 1'b0;
	localparam bit KIND_READOUT = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] value;
		logic       is_last;
		logic       waiting;
		logic       ovf;
		logic       rd_empty;
	} emitted_t;

	// Mirror of the deframer state. Every accepted input transaction is folded in and the bytes
	// it should cause are queued; every accepted output transaction is matched against them.
	class deframe_mirror;
		logic [7:0]   poly;
		logic [7:0]   init_val;
		logic [7:0]   ack_c;
		logic [7:0]   retx_c;
		frame_phase_t phase;
		int           cnt;
		logic [7:0]   run_crc;
		logic [7:0]   partial [PKT];
		logic [7:0]   ring [RING*PKT];
		int           wr_slot;
		int           rd_slot;
		int           stored;
		bit           ovf_flag;
		emitted_t     due_bytes [$];
		int           errors;

		function new();
			poly     = pdca_pkg::POLY_RESET;
			init_val = pdca_pkg::INITIAL_RESET;
			ack_c    = pdca_pkg::ACK_RESET;
			retx_c   = pdca_pkg::RETX_RESET;
			phase    = PH_LEN;
			cnt      = 0;
			run_crc  = pdca_pkg::INITIAL_RESET;
			wr_slot  = 0;
			rd_slot  = 0;
			stored   = 0;
			ovf_flag = 0;
			errors   = 0;
		endfunction

		function void write_reg(logic [pdca_pkg::CFG_INDEX_W-1:0] idx, logic [7:0] v);
			case (idx)
				pdca_pkg::CFG_IDX_POLY: poly = v;
				pdca_pkg::CFG_IDX_INITIAL: init_val = v;
				pdca_pkg::CFG_IDX_ACK: ack_c = v;
				pdca_pkg::CFG_IDX_RETX: retx_c = v;
				default: ;
			endcase
		endfunction

		// One byte through an MSB-first CRC-8 with the current generator.
		function logic [7:0] crc8(logic [7:0] c, logic [7:0] b);
			logic [7:0] r;
			r = c ^ b;
			repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ poly) : {r[6:0], 1'b0};
			return r;
		endfunction

		function void add(bit kind, logic [7:0] value, bit is_last, bit rd_empty);
			emitted_t e;
			e.kind     = kind;
			e.value    = value;
			e.is_last  = is_last;
			e.waiting  = (stored != 0);
			e.ovf      = ovf_flag;
			e.rd_empty = rd_empty;
			due_bytes.push_back(e);
		endfunction

		// A control packet is length 1, the code, then fill bytes up to the CRC.
		function bit is_control(logic [7:0] code);
			if (partial[0] != 8'd1 || partial[1] != code)
				return 0;
			for (int i = 2; i <= DB; i++)
				if (partial[i] != pdca_pkg::FILL_BYTE)
					return 0;
			return 1;
		endfunction

		function void emit_control(logic [7:0] code);
			logic [7:0] c;
			c = crc8(init_val, 8'd1);
			add(KIND_LINK, 8'd1, 0, 0);
			c = crc8(c, code);
			add(KIND_LINK, code, 0, 0);
			for (int i = 2; i <= DB; i++) begin
				c = crc8(c, pdca_pkg::FILL_BYTE);
				add(KIND_LINK, pdca_pkg::FILL_BYTE, 0, 0);
			end
			add(KIND_LINK, c, 1, 0);
		endfunction

		function void note_item(op_t op, logic [7:0] b);
			int base;
			if (op == OP_READ) begin
				// A read on an empty ring answers with a single flagged byte.
				if (stored == 0) begin
					add(KIND_READOUT, 8'd0, 1, 1);
					return;
				end
				base    = rd_slot * PKT;
				rd_slot = (rd_slot + 1 >= RING) ? 0 : rd_slot + 1;
				stored--;
				for (int i = 0; i < PKT; i++)
					add(KIND_READOUT, ring[base + i], i == PKT - 1, 0);
				return;
			end
			case (phase)
				PH_DATA: begin
					partial[1 + cnt] = b;
					run_crc = crc8(run_crc, b);
					cnt++;
					if (cnt >= DB) begin
						cnt   = 0;
						phase = PH_CRC;
					end
				end
				PH_CRC: begin
					phase = PH_LEN;
					partial[PKT-1] = b;
					// A bad CRC is judged first; retransmit wins over ack when the codes match.
					if (b != run_crc || is_control(retx_c)) begin
						emit_control(retx_c);
					end else if (!is_control(ack_c)) begin
						if (stored >= RING) begin
							ovf_flag = 1;
						end else begin
							for (int i = 0; i < PKT; i++)
								ring[wr_slot*PKT + i] = partial[i];
							wr_slot = (wr_slot + 1 >= RING) ? 0 : wr_slot + 1;
							stored++;
						end
						emit_control(ack_c);
					end
				end
				default: begin
					partial[0] = b;
					run_crc = crc8(init_val, b);
					cnt = 0;
					phase = PH_DATA;
				end
			endcase
		endfunction

		function void cmp(string name, int unsigned e, int unsigned a);
			if (e != a) begin
				$error("%s: expected %0h, got %0h", name, e, a);
				errors++;
			end
		endfunction

		function void check_byte(emitted_t got);
			emitted_t e;
			if (due_bytes.size() == 0) begin
				$error("output byte %0h with nothing expected", got.value);
				errors++;
				return;
			end
			e = due_bytes.pop_front();
			cmp("out_kind", e.kind, got.kind);
			cmp("out_byte", e.value, got.value);
			cmp("last", e.is_last, got.is_last);
			cmp("packets_waiting", e.waiting, got.waiting);
			cmp("overflow", e.ovf, got.ovf);
			cmp("read_empty", e.rd_empty, got.rd_empty);
		endfunction

		function int pending();
			return due_bytes.size();
		endfunction

		function bit at_frame_start();
			return phase == PH_LEN;
		endfunction

		function void drain_check();
			if (due_bytes.size() != 0) begin
				$error("%0d expected output bytes never arrived", due_bytes.size());
				errors++;
			end
		endfunction
	endclass

	logic                             clk;
	logic                             arst_n;
	logic                             s_axis_tvalid;
	logic                             s_axis_tready;
	logic [7:0]                       s_axis_tdata;
	logic                             s_axis_tuser;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready;
	logic [15:0]                      m_axis_tdata;
	logic                             m_axis_tuser;
	logic                             m_axis_tlast;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [pdca_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [7:0]                       cfg_data;

	deframe_mirror mirror;
	// Random idling on both sides; cleared for one long stretch.
	bit            gaps_on;
	// Frame being assembled for sending: length, data bytes, CRC.
	logic [7:0]    frame_buf [PKT];

	packet_deframer_crc_ack #(
		.DATA_BYTES(DB),
		.RING_PACKETS(RING)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Output side: every accepted transaction is checked, then tready is redrawn for the next
	// edge. Values read here are the ones from before the edge, so the order of processes within
	// the time step does not matter.
	always @(posedge clk) begin
		emitted_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.kind     = m_axis_tuser;
			got.value    = m_axis_tdata[7:0];
			got.is_last  = m_axis_tlast;
			got.waiting  = m_axis_tdata[8];
			got.ovf      = m_axis_tdata[9];
			got.rd_empty = m_axis_tdata[10];
			mirror.check_byte(got);
		end
		m_axis_tready <= gaps_on ? ($urandom_range(0, 99) >= 25) : 1'b1;
	end

	// Offers one input transaction and returns at the edge where it is taken. tvalid is left
	// high so that a following item goes out back to back; the caller lowers it when done.
	task automatic send_item(input op_t op, input logic [7:0] b);
		while (gaps_on && $urandom_range(0, 99) < 25) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		mirror.note_item(op, b);
	endtask

	// Pads out a partly received frame so that the next byte is a length byte.
	task automatic finish_frame();
		while (!mirror.at_frame_start())
			send_item(OP_RX, 8'($urandom_range(0, 255)));
	endtask

	// Holds the sender back until every expected byte has come out and the block has settled.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (mirror.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Writes all four registers back to back; only called while the block is idle.
	task automatic program_regs(input logic [7:0] poly, input logic [7:0] init_val,
			input logic [7:0] ack_c, input logic [7:0] retx_c);
		logic [pdca_pkg::CFG_INDEX_W-1:0] idx [4];
		logic [7:0]                       vals [4];
		idx  = '{pdca_pkg::CFG_IDX_POLY, pdca_pkg::CFG_IDX_INITIAL, pdca_pkg::CFG_IDX_ACK,
			pdca_pkg::CFG_IDX_RETX};
		vals = '{poly, init_val, ack_c, retx_c};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= vals[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			mirror.write_reg(idx[i], vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic enter_phase(input logic [7:0] poly, input logic [7:0] init_val,
			input logic [7:0] ack_c, input logic [7:0] retx_c);
		finish_frame();
		wait_drained();
		program_regs(poly, init_val, ack_c, retx_c);
	endtask

	function automatic void fill_random();
		for (int i = 0; i <= DB; i++)
			frame_buf[i] = 8'($urandom_range(0, 255));
	endfunction

	function automatic void fill_const(input logic [7:0] v);
		for (int i = 0; i <= DB; i++)
			frame_buf[i] = v;
	endfunction

	function automatic void fill_control(input logic [7:0] code);
		frame_buf[0] = 8'd1;
		frame_buf[1] = code;
		for (int i = 2; i <= DB; i++)
			frame_buf[i] = pdca_pkg::FILL_BYTE;
	endfunction

	// Appends the CRC under the current registers, or a wrong one when asked.
	function automatic void seal(input bit corrupt);
		logic [7:0] c;
		c = mirror.init_val;
		for (int i = 0; i <= DB; i++)
			c = mirror.crc8(c, frame_buf[i]);
		frame_buf[PKT-1] = corrupt ? (c ^ 8'($urandom_range(1, 255))) : c;
	endfunction

	// Sends the frame from a frame boundary; reads may be slipped in between its bytes.
	task automatic send_frame(input bit interleave);
		finish_frame();
		for (int i = 0; i < PKT; i++) begin
			if (interleave && $urandom_range(0, 99) < 6)
				send_item(OP_READ, 8'($urandom_range(0, 255)));
			send_item(OP_RX, frame_buf[i]);
		end
	endtask

	initial begin
		#2_000_000;
		$display("tb NOT OK");
		$finish;
	end

	initial begin
		mirror        = new();
		gaps_on       = 1;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= 8'd0;
		s_axis_tuser  <= OP_RX;
		m_axis_tready <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_index     <= pdca_pkg::CFG_IDX_POLY;
		cfg_data      <= 8'd0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset register values. First a read of the empty ring.
		send_item(OP_READ, 8'h00);
		// An acknowledge packet with a broken CRC is answered with the retransmit packet.
		fill_control(mirror.ack_c);
		seal(1);
		send_frame(0);
		// A good acknowledge packet is swallowed without any output; reads may slip in.
		fill_control(mirror.ack_c);
		seal(0);
		send_frame(1);

		// Equal ack and retransmit codes: the request has to be read as a retransmit.
		enter_phase(8'hff, 8'h5a, 8'h42, 8'h42);
		fill_control(mirror.retx_c);
		seal(0);
		send_frame(0);

		// Long stretch without idling: fill the ring with good packets, the last one of which
		// is dropped while still acknowledged, then read two back with the overflow flag set.
		gaps_on = 0;
		enter_phase(8'h31, 8'hff, 8'h00, 8'hff);
		fill_const(8'h00);
		seal(0);
		send_frame(0);
		fill_const(8'hff);
		seal(0);
		send_frame(0);
		repeat (RING - 1) begin
			fill_random();
			if ($urandom_range(0, 1) == 0)
				frame_buf[1] = mirror.ack_c;
			seal(0);
			send_frame(0);
		end
		repeat (2) send_item(OP_READ, 8'($urandom_range(0, 255)));
		gaps_on = 1;

		// Close any open frame, let every expected byte arrive and make sure nothing follows.
		finish_frame();
		wait_drained();
		mirror.drain_check();
		if (mirror.errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
